// File: rtl/core/smo_pkg.sv
// ----------------------------------------------------------------------------
// smo_pkg
// Shared constants for the stack machine operations unit.
// ----------------------------------------------------------------------------
package smo_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_ALL   = 3'd1;
  localparam logic [2:0] OP_TOP   = 3'd2;
  localparam logic [2:0] OP_SWAP  = 3'd3;
  localparam logic [2:0] OP_ADD   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: rtl/core/stack_machine_ops_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_ops_unit
// Bounded stack machine: push, print-all, print-top, swap and add on a
// RAM-held stack, one operation per input beat.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, in_req_type,         | input
//           | in_push_value                           |
//   out     | out_valid/out_ready, out_value,         | output
//           | out_has_value, out_status, out_last     |
//
// Sequencing follows the single RAM read port and its registered read:
// print-top reads the top entry, add and swap the top two, and print-all
// reads n entries top down, one result beat per cycle unless stalled.
// in_ready is high only while the unit is idle. Result beats sit in an
// output register; a stalled out_ready holds each beat-issuing state.
// Synchronous active-low reset empties the stack; no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_ops_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_req_type,
  input  smo_pkg::word_t        in_push_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smo_pkg::word_t        out_value,
  output logic                  out_has_value,
  output logic [1:0]            out_status,
  output logic                  out_last
);
  import smo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TOP,
    S_PALL,
    S_SEC,
    S_ADD,
    S_SWAP,
    S_SWAP2
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  word_t             val_r, val_nxt;
  word_t             opa_r, opa_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_value_r, out_value_nxt;
  logic              out_has_value_r, out_has_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              out_free;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  word_t             sum;

  smo_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_m2   = cnt_r - CNT_W'(2);
  assign sum      = word_t'(ram_rdata) + opa_r;

  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    val_nxt           = val_r;
    opa_nxt           = opa_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_value_nxt     = out_value_r;
    out_has_value_nxt = out_has_value_r;
    out_status_nxt    = out_status_r;
    out_last_nxt      = out_last_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_waddr         = '0;
    ram_raddr         = '0;
    ram_wdata         = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_req_type;
          val_nxt   = in_push_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r) inside
          OP_PUSH: begin
            if (out_free) begin
              out_valid_nxt     = 1'b1;
              out_value_nxt     = '0;
              out_has_value_nxt = 1'b0;
              out_last_nxt      = 1'b1;
              state_nxt         = S_IDLE;
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                ram_we         = 1'b1;
                ram_waddr      = cnt_r[ADDR_W-1:0];
                cnt_nxt        = cnt_r + CNT_W'(1);
              end
            end
          end
          OP_ALL: begin
            if (cnt_r == '0) begin
              if (out_free) begin
                out_valid_nxt     = 1'b1;
                out_value_nxt     = '0;
                out_has_value_nxt = 1'b0;
                out_status_nxt    = ST_OK;
                out_last_nxt      = 1'b1;
                state_nxt         = S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[ADDR_W-1:0];
              idx_nxt   = cnt_m1[ADDR_W-1:0];
              state_nxt = S_PALL;
            end
          end
          OP_TOP: begin
            if (cnt_r == '0) begin
              if (out_free) begin
                out_valid_nxt     = 1'b1;
                out_value_nxt     = '0;
                out_has_value_nxt = 1'b0;
                out_status_nxt    = ST_EMPTY;
                out_last_nxt      = 1'b1;
                state_nxt         = S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[ADDR_W-1:0];
              state_nxt = S_TOP;
            end
          end
          OP_SWAP, OP_ADD: begin
            if (cnt_r < CNT_W'(2)) begin
              if (out_free) begin
                out_valid_nxt     = 1'b1;
                out_value_nxt     = '0;
                out_has_value_nxt = 1'b0;
                out_status_nxt    = ST_SHORT;
                out_last_nxt      = 1'b1;
                state_nxt         = S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[ADDR_W-1:0];
              state_nxt = S_SEC;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_nxt     = 1'b1;
              out_value_nxt     = '0;
              out_has_value_nxt = 1'b0;
              out_status_nxt    = ST_OK;
              out_last_nxt      = 1'b1;
              state_nxt         = S_IDLE;
            end
          end
        endcase
      end
      S_TOP: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_value_nxt     = word_t'(ram_rdata);
          out_has_value_nxt = 1'b1;
          out_status_nxt    = ST_OK;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_PALL: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_value_nxt     = word_t'(ram_rdata);
          out_has_value_nxt = 1'b1;
          out_status_nxt    = ST_OK;
          out_last_nxt      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - ADDR_W'(1);
            idx_nxt   = idx_r - ADDR_W'(1);
          end
        end
      end
      S_SEC: begin
        opa_nxt   = word_t'(ram_rdata);
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[ADDR_W-1:0];
        state_nxt = (op_r == OP_ADD) ? S_ADD : S_SWAP;
      end
      S_ADD: begin
        if (out_free) begin
          ram_we            = 1'b1;
          ram_waddr         = cnt_m2[ADDR_W-1:0];
          ram_wdata         = sum;
          cnt_nxt           = cnt_m1;
          out_valid_nxt     = 1'b1;
          out_value_nxt     = '0;
          out_has_value_nxt = 1'b0;
          out_status_nxt    = ST_OK;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m1[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        if (out_free) begin
          ram_we            = 1'b1;
          ram_waddr         = cnt_m2[ADDR_W-1:0];
          ram_wdata         = opa_r;
          out_valid_nxt     = 1'b1;
          out_value_nxt     = '0;
          out_has_value_nxt = 1'b0;
          out_status_nxt    = ST_OK;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r            <= op_nxt;
    val_r           <= val_nxt;
    opa_r           <= opa_nxt;
    idx_r           <= idx_nxt;
    out_value_r     <= out_value_nxt;
    out_has_value_r <= out_has_value_nxt;
    out_status_r    <= out_status_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_has_value = out_has_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// File: rtl/core/smo_ram.sv
// ----------------------------------------------------------------------------
// smo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/stack_machine_ops_unit_test.sv
// ----------------------------------------------------------------------------
// stack_machine_ops_unit_test
// Self-checking bench for the stack machine operations unit. A short
// directed table covers the empty, single-entry, wrap-around and unknown-code
// corners; random traffic then runs in three phases of sender and receiver
// stalls (none in the last), with fill-to-overflow and drain-to-underflow
// bursts. Every beat is checked field by field vs. table or stack predictor.
// ----------------------------------------------------------------------------
module stack_machine_ops_unit_test;
  import smo_pkg::*;

  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;
  localparam int         DIR_N       = 25;
  localparam int         PHASE_ITEMS = 95;

  typedef struct packed {
    word_t      value;
    logic       has;
    logic [1:0] status;
    logic       last;
  } reply_t;

  typedef struct packed {
    logic [2:0] op;
    word_t      val;
    logic       typed;
    reply_t     exp;
  } row_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [2:0] in_req_type   = OP_PUSH;
  word_t      in_push_value = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  word_t      out_value;
  logic       out_has_value;
  logic [1:0] out_status;
  logic       out_last;

  word_t  stack_words [STACK_DEPTH];
  int     fill_level;
  reply_t stack_replies [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int counted_items;
  int fail_cnt;
  int beats_checked;
  int peak_fill;
  int overflow_rejects;
  int short_rejects;
  int empty_tops;
  int ops_seen [8];

  row_t dir_rows [DIR_N] = '{
    '{OP_ALL,      32'sd0,           1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_TOP,      32'sd0,           1'b1, '{32'sd0,           1'b0, ST_EMPTY, 1'b1}},
    '{OP_SWAP,     32'sd0,           1'b1, '{32'sd0,           1'b0, ST_SHORT, 1'b1}},
    '{OP_ADD,      32'sd0,           1'b1, '{32'sd0,           1'b0, ST_SHORT, 1'b1}},
    '{OP_PUSH,     32'sh7fff_ffff,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_SWAP,     32'sh0000_ffff,   1'b1, '{32'sd0,           1'b0, ST_SHORT, 1'b1}},
    '{OP_ADD,      32'shffff_0000,   1'b1, '{32'sd0,           1'b0, ST_SHORT, 1'b1}},
    '{OP_TOP,      32'sd0,           1'b1, '{32'sh7fff_ffff,   1'b1, ST_OK,    1'b1}},
    '{OP_PUSH,     32'sd1,           1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_ADD,      32'sd0,           1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_TOP,      32'sd0,           1'b1, '{32'sh8000_0000,   1'b1, ST_OK,    1'b1}},
    '{OP_PUSH,     32'sh8000_0000,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_ADD,      32'sd0,           1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_TOP,      32'sd0,           1'b1, '{32'sd0,           1'b1, ST_OK,    1'b1}},
    '{OP_PUSH,     32'shffff_ffff,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_SWAP,     32'sd0,           1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_ALL,      32'sd0,           1'b0, '0},
    '{OP_RSVD_LO,  32'shffff_ffff,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_RSVD_MID, 32'sh8000_0000,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_RSVD_HI,  32'sh7fff_ffff,   1'b1, '{32'sd0,           1'b0, ST_OK,    1'b1}},
    '{OP_PUSH,     32'sh5555_aaaa,   1'b0, '0},
    '{OP_ALL,      32'sd0,           1'b0, '0},
    '{OP_PUSH,     32'shaaaa_5555,   1'b0, '0},
    '{OP_ADD,      32'sd0,           1'b0, '0},
    '{OP_ALL,      32'sd0,           1'b0, '0}
  };

  stack_machine_ops_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_has_value (out_has_value),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Stack predictor: updates the local stack and queues the beats one op owes.
  function automatic void exec_stack_op(logic [2:0] op, word_t val);
    reply_t r;
    r = '{value: '0, has: 1'b0, status: ST_OK, last: 1'b1};
    ops_seen[op]++;
    case (op)
      OP_PUSH: begin
        if (fill_level >= STACK_DEPTH) begin
          r.status = ST_FULL;
          overflow_rejects++;
        end else begin
          stack_words[fill_level] = val;
          fill_level++;
          if (fill_level > peak_fill) peak_fill = fill_level;
        end
      end
      OP_ALL: begin
        for (int i = fill_level - 1; i > 0; i--) begin
          stack_replies.push_back('{value: stack_words[i], has: 1'b1, status: ST_OK,
                                    last: 1'b0});
        end
        if (fill_level > 0) begin
          r.value = stack_words[0];
          r.has   = 1'b1;
        end
      end
      OP_TOP: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
          empty_tops++;
        end else begin
          r.value = stack_words[fill_level-1];
          r.has   = 1'b1;
        end
      end
      OP_SWAP: begin
        if (fill_level < 2) begin
          r.status = ST_SHORT;
          short_rejects++;
        end else begin
          word_t t;
          t = stack_words[fill_level-1];
          stack_words[fill_level-1] = stack_words[fill_level-2];
          stack_words[fill_level-2] = t;
        end
      end
      OP_ADD: begin
        if (fill_level < 2) begin
          r.status = ST_SHORT;
          short_rejects++;
        end else begin
          stack_words[fill_level-2] = stack_words[fill_level-2] +
                                      stack_words[fill_level-1];
          fill_level--;
        end
      end
      default: ;
    endcase
    stack_replies.push_back(r);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return 32'shffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic [2:0] op, input word_t val,
                           input logic typed = 1'b0, input reply_t exp = '0);
    int n0;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_push_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n0 = stack_replies.size();
    exec_stack_op(op, val);
    if (typed) begin
      while (stack_replies.size() > n0) void'(stack_replies.pop_back());
      stack_replies.push_back(exp);
    end
    counted_items++;
  endtask

  task automatic random_step();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 3) begin
      // fill to the brim, then overflow
      while (fill_level < STACK_DEPTH) send_beat(OP_PUSH, rand_word());
      k = $urandom_range(1, 3);
      repeat (k) send_beat(OP_PUSH, rand_word());
      send_beat(OP_ALL, $urandom());
    end else if (r < 7) begin
      // fold the stack down, then underflow
      while (fill_level >= 2) send_beat(OP_ADD, $urandom());
      send_beat(OP_ADD, $urandom());
      send_beat(OP_SWAP, $urandom());
      send_beat(OP_TOP, $urandom());
    end else if (r < 47) send_beat(OP_PUSH, rand_word());
    else if (r < 55)     send_beat(OP_ALL, $urandom());
    else if (r < 69)     send_beat(OP_TOP, $urandom());
    else if (r < 83)     send_beat(OP_SWAP, $urandom());
    else if (r < 95)     send_beat(OP_ADD, $urandom());
    else                 send_beat(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), $urandom());
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (stack_replies.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected beat: value=%h has=%0d status=%0d last=%0d",
                   out_value, out_has_value, out_status, out_last);
      end else begin
        reply_t e;
        e = stack_replies.pop_front();
        beats_checked++;
        if (out_value !== e.value || out_has_value !== e.has ||
            out_status !== e.status || out_last !== e.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"mismatch beat %0d: exp value=%h has=%0d status=%0d last=%0d,",
                      " got value=%h has=%0d status=%0d last=%0d"},
                     beats_checked, e.value, e.has, e.status, e.last,
                     out_value, out_has_value, out_status, out_last);
        end
      end
    end
  end

  initial begin
    int snd_pct [3];
    int rcv_pct [3];
    int goal;
    snd_pct = '{36, 70, 0};
    rcv_pct = '{70, 36, 0};
    fill_level   = 0;
    snd_idle_pct = snd_pct[0];
    rcv_idle_pct = rcv_pct[0];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++)
      send_beat(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp);
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = snd_pct[ph];
      rcv_idle_pct = rcv_pct[ph];
      goal = counted_items + PHASE_ITEMS;
      while (counted_items < goal) random_step();
    end
    in_valid <= 1'b0;
    while (stack_replies.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("ran %0d ops: push %0d, print-all %0d, print-top %0d, swap %0d, add %0d",
             counted_items, ops_seen[OP_PUSH], ops_seen[OP_ALL], ops_seen[OP_TOP],
             ops_seen[OP_SWAP], ops_seen[OP_ADD]);
    $display("unknown %0d; %0d result beats compared; peak depth %0d, %0d overflows,",
             ops_seen[OP_RSVD_LO] + ops_seen[OP_RSVD_MID] + ops_seen[OP_RSVD_HI],
             beats_checked, peak_fill, overflow_rejects);
    $display("%0d short, %0d empty top", short_rejects, empty_tops);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout, %0d beats still owed", stack_replies.size());
    $display("status: fail");
    $finish;
  end

endmodule
